// ===== rtl/c3f_pkg.sv =====
// Shared constants and types of the 3x3 image filter.
package c3f_pkg;

  // Default size limits of the line store and the row counter
  localparam int unsigned C3F_MAX_WIDTH  = 1024;
  localparam int unsigned C3F_MAX_HEIGHT = 4096;

  // Field widths
  localparam int unsigned PIX_W          = 8;
  localparam int unsigned LINE_WIDTH_W   = 11;
  localparam int unsigned FRAME_HEIGHT_W = 13;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 13;

  // Reset values of the size registers
  localparam int unsigned LINE_WIDTH_RST   = 512;
  localparam int unsigned FRAME_HEIGHT_RST = 512;

  // floor(s / 9) == (s * 7282) >> 16 for every box sum s up to 9 * 255
  localparam logic [12:0] BOX_RECIP = 13'd7282;
  localparam int unsigned BOX_SHIFT = 16;

  // Register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_FILTER_MODE  = 2'd2
  } cfg_reg_e;

  // Filter modes; the unused code falls back to box smoothing
  typedef enum logic [MODE_W-1:0] {
    MODE_BOX     = 2'd0,
    MODE_SOBEL   = 2'd1,
    MODE_LAPLACE = 2'd2
  } mode_e;

  typedef logic [PIX_W-1:0] pix_t;

  // Per-item window control worked out from the raster position
  typedef struct packed {
    logic out_en;   // item releases a result
    logic top_m;    // row above the centre lies outside the frame
    logic bot_m;    // row below the centre lies outside the frame
    logic left_m;   // column left of the centre lies outside the frame
    logic right_m;  // column right of the centre lies outside the frame
    logic last;     // result is the final one of the frame
  } win_ctrl_t;

endpackage

// ===== rtl/c3f_if.sv =====
// Handshake channels of the 3x3 image filter: pixel input, result output, configuration.
interface c3f_pix_in_if;
  import c3f_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  pix_t pixel_in;
  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface c3f_pix_out_if;
  import c3f_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel_out;
  logic frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface c3f_cfg_if;
  import c3f_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/c3f_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module c3f_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/conv3x3_image_filter.sv =====
// 3x3 image filter (box smooth, Sobel magnitude, 4-neighbour Laplacian) over a raster stream.
//
// Gray pixels enter in raster order, one per clock sustained while results are taken;
// the result for a pixel leaves once the item one line plus one pixel later has been taken, and
// line_width+1 padding ticks after the last pixel flush the frame. Borders are zero padded and
// results clamped to 0..255. Pixel rate is set by the line store, one RAM of MAX_WIDTH words
// holding the two previous lines of each column: one read and one write per pixel, with the
// write of the previous pixel forwarded when both fall on the same column. A result passes the
// read, window, sum and output registers after the input transfer that releases it. No clearing
// pass is needed after reset: entries from before the current frame only ever feed masked taps.
// Configuration writes are taken at once; size writes restart the frame position.
module conv3x3_image_filter #(
  parameter int unsigned MAX_WIDTH  = c3f_pkg::C3F_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = c3f_pkg::C3F_MAX_HEIGHT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  c3f_cfg_if.sink      cfg_i,
  c3f_pix_in_if.sink   pix_i,
  c3f_pix_out_if.source pix_o
);

  import c3f_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);   // holds the width itself
  localparam int unsigned AW = $clog2(MAX_WIDTH);       // column address
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);  // row count runs to height+1
  localparam int unsigned W_RST = (LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RST;
  localparam int unsigned H_RST =
    (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

  // ---------------------------------------------------------------------------
  // Configuration: sizes are stored already clamped to 1..MAX
  // ---------------------------------------------------------------------------
  logic [CW-1:0]     eff_w_q, eff_w_d;
  logic [RW-1:0]     eff_h_q, eff_h_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic              cfg_acc;
  logic              pos_clr;
  logic [31:0]       w_raw, h_raw;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign w_raw       = 32'(cfg_i.data[LINE_WIDTH_W-1:0]);
  assign h_raw       = 32'(cfg_i.data[FRAME_HEIGHT_W-1:0]);

  always_comb begin
    eff_w_d = eff_w_q;
    eff_h_d = eff_h_q;
    mode_d  = mode_q;
    pos_clr = 1'b0;
    if (cfg_acc) begin
      case (cfg_i.index)
        REG_LINE_WIDTH: begin
          if (w_raw == 32'd0) begin
            eff_w_d = CW'(1);
          end else if (w_raw > 32'(MAX_WIDTH)) begin
            eff_w_d = CW'(MAX_WIDTH);
          end else begin
            eff_w_d = CW'(w_raw);
          end
          pos_clr = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          if (h_raw == 32'd0) begin
            eff_h_d = RW'(1);
          end else if (h_raw > 32'(MAX_HEIGHT)) begin
            eff_h_d = RW'(MAX_HEIGHT);
          end else begin
            eff_h_d = RW'(h_raw);
          end
          pos_clr = 1'b1;
        end
        REG_FILTER_MODE: begin
          mode_d = cfg_i.data[MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= CW'(W_RST);
      eff_h_q <= RW'(H_RST);
      mode_q  <= MODE_BOX;
    end else begin
      eff_w_q <= eff_w_d;
      eff_h_q <= eff_h_d;
      mode_q  <= mode_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or moving on
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic out_adv, s3_free, s2_free, s1_go, in_acc;

  assign out_adv     = !out_valid_q || pix_o.ready;
  assign s3_free     = !s3_valid_q || out_adv;
  assign s2_free     = !s2_valid_q || s3_free;
  assign s1_go       = s1_valid_q && s2_free;
  assign pix_i.ready = !s1_valid_q || s2_free;
  assign in_acc      = pix_i.valid && pix_i.ready;

  // ---------------------------------------------------------------------------
  // Stage 0: raster position, border flags, line store read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [RW-1:0] hp1;
  logic          c0, c1;
  win_ctrl_t     ctrl;
  pix_t          cur;

  assign hp1 = eff_h_q + RW'(1);
  assign c0  = (col_q == CW'(0));
  assign c1  = (col_q == CW'(1));

  always_comb begin
    if (c0) begin
      // centre lies at the end of the line two rows up
      ctrl.out_en = (row_q >= RW'(2)) && (row_q <= hp1);
      ctrl.top_m  = (row_q == RW'(2));
      ctrl.bot_m  = (row_q == hp1);
    end else begin
      ctrl.out_en = (row_q >= RW'(1)) && (row_q <= eff_h_q);
      ctrl.top_m  = (row_q == RW'(1));
      ctrl.bot_m  = (row_q == eff_h_q);
    end
    ctrl.left_m  = c1 || (c0 && (eff_w_q == CW'(1)));
    ctrl.right_m = c0;
    ctrl.last    = c0 && (row_q == hp1);
    // padding ticks and pixels past the frame count as black
    cur = (!pix_i.kind && (row_q < eff_h_q)) ? pix_i.pixel_in : '0;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (pos_clr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (ctrl.last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q + CW'(1) == eff_w_q) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: word per column = {pixel two rows up, pixel one row up}
  // ---------------------------------------------------------------------------
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*PIX_W-1:0]   ram_wdata, ram_rdata, rd_word;
  logic [AW-1:0]        s1_addr_q;
  pix_t                 s1_cur_q;
  win_ctrl_t            s1_ctrl_q;
  logic                 fwd_hit_q;
  logic [2*PIX_W-1:0]   fwd_data_q;

  c3f_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (col_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Write of the retiring item bypasses the RAM when the new read hits it
  assign rd_word   = fwd_hit_q ? fwd_data_q : ram_rdata;
  assign ram_we    = s1_go;
  assign ram_waddr = s1_addr_q;
  assign ram_wdata = {rd_word[PIX_W-1:0], s1_cur_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= in_acc;
      if (in_acc) begin
        fwd_hit_q <= s1_go && (s1_addr_q == col_q[AW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_addr_q  <= col_q[AW-1:0];
      s1_cur_q   <= cur;
      s1_ctrl_q  <= ctrl;
      fwd_data_q <= ram_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: shift the new column into the 3x3 window
  // ---------------------------------------------------------------------------
  pix_t      win_q [3][3];
  win_ctrl_t s2_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_go && s1_ctrl_q.out_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_word[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_word[PIX_W-1:0];
      win_q[2][2] <= s1_cur_q;
      s2_ctrl_q   <= s1_ctrl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: zero padding and kernel sums
  // ---------------------------------------------------------------------------
  pix_t               pm [3][3];
  logic [9:0]         row_sum [3];
  logic [11:0]        box_sum;
  logic [9:0]         gy_pos, gy_neg, gx_pos, gx_neg, lap_nb, lap_c;
  logic signed [11:0] gx, gy, lap;
  logic [11:0]        box_q;
  logic signed [11:0] gx_q, gy_q, lap_q;
  logic               s3_last_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if ((r == 0 && s2_ctrl_q.top_m) || (r == 2 && s2_ctrl_q.bot_m) ||
            (c == 0 && s2_ctrl_q.left_m) || (c == 2 && s2_ctrl_q.right_m)) begin
          pm[r][c] = '0;
        end else begin
          pm[r][c] = win_q[r][c];
        end
      end
    end
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = 10'(pm[r][0]) + 10'(pm[r][1]) + 10'(pm[r][2]);
    end
    box_sum = 12'(row_sum[0]) + 12'(row_sum[1]) + 12'(row_sum[2]);
    // Sobel: weights 1,2,1 across the outer rows and columns
    gy_pos = 10'(pm[2][0]) + 10'({pm[2][1], 1'b0}) + 10'(pm[2][2]);
    gy_neg = 10'(pm[0][0]) + 10'({pm[0][1], 1'b0}) + 10'(pm[0][2]);
    gx_pos = 10'(pm[0][2]) + 10'({pm[1][2], 1'b0}) + 10'(pm[2][2]);
    gx_neg = 10'(pm[0][0]) + 10'({pm[1][0], 1'b0}) + 10'(pm[2][0]);
    gy     = $signed(12'(gy_pos)) - $signed(12'(gy_neg));
    gx     = $signed(12'(gx_pos)) - $signed(12'(gx_neg));
    // Laplacian: four neighbours minus four times the centre
    lap_nb = 10'(pm[0][1]) + 10'(pm[1][0]) + 10'(pm[1][2]) + 10'(pm[2][1]);
    lap_c  = {pm[1][1], 2'b00};
    lap    = $signed(12'(lap_nb)) - $signed(12'(lap_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_free) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_valid_q) begin
      box_q     <= box_sum;
      gx_q      <= gx;
      gy_q      <= gy;
      lap_q     <= lap;
      s3_last_q <= s2_ctrl_q.last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: mode select, divide by nine, magnitude, clamp
  // ---------------------------------------------------------------------------
  logic [24:0] box_prod;
  logic [10:0] abs_x, abs_y;
  logic [11:0] sob;
  pix_t        res;
  pix_t        out_pix_q;
  logic        out_last_q;

  always_comb begin
    box_prod = 25'(box_q) * 25'(BOX_RECIP);
    abs_x    = gx_q[11] ? 11'(-gx_q) : 11'(gx_q);
    abs_y    = gy_q[11] ? 11'(-gy_q) : 11'(gy_q);
    sob      = 12'(abs_x) + 12'(abs_y);
    case (mode_q)
      MODE_SOBEL: begin
        res = (sob > 12'd255) ? 8'hFF : sob[PIX_W-1:0];
      end
      MODE_LAPLACE: begin
        if (lap_q[11]) begin
          res = '0;
        end else if (lap_q > 12'sd255) begin
          res = 8'hFF;
        end else begin
          res = lap_q[PIX_W-1:0];
        end
      end
      default: begin
        res = box_prod[BOX_SHIFT+PIX_W-1:BOX_SHIFT];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s3_valid_q) begin
      out_pix_q  <= res;
      out_last_q <= s3_last_q;
    end
  end

  assign pix_o.valid      = out_valid_q;
  assign pix_o.pixel_out  = out_pix_q;
  assign pix_o.frame_last = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A forwarded read must match the write that retired on the same edge
  a_fwd_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc) && fwd_hit_q) |-> ($past(ram_we) && ($past(ram_waddr) == s1_addr_q)))
    else $error("line store forward without matching write");

  // Column position always lies inside the line
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < eff_w_q)
    else $error("column count beyond line width");

  // Row position never passes the flush row
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= hp1)
    else $error("row count beyond frame flush");

  // The final result of a frame restarts the raster position
  a_last_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && ctrl.last && !pos_clr) |=> ((col_q == CW'(0)) && (row_q == RW'(0))))
    else $error("frame end did not restart position");

endmodule
